[hw/rtl/mfs_pkg.sv]
package mfs_pkg;

    // Width of the wiper converter; the filtered position carries this many bits.
    localparam int ADC_BITS = 10;
    localparam int POS_W    = ADC_BITS;

    localparam int WIPER_W  = 10;
    localparam int TOUCH_W  = 16;
    localparam int TARGET_W = 14;
    localparam int HYST_W   = 10;
    localparam int BAND_W   = 14;
    localparam int DUTY_W   = 8;
    localparam int MSB_W    = 7;
    localparam int LSB_W    = 3;

    // Unsigned sum width for the input filter compare.
    localparam int FILT_W = ((POS_W > HYST_W) ? POS_W : HYST_W) + 1;
    // Signed width for the drive decision (target +/- band, position).
    localparam int DEC_W  = ((POS_W > TARGET_W) ? POS_W : TARGET_W) + 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FADER_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_BAND       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_DUTY       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DUTY       = 3'd5;

    localparam logic              RST_FADER_ENABLE    = 1'b1;
    localparam logic [HYST_W-1:0] RST_HYSTERESIS      = 10'd4;
    localparam logic [TOUCH_W-1:0] RST_TOUCH_THRESHOLD = 16'd1000;
    localparam logic [BAND_W-1:0] RST_FAST_BAND       = 14'd150;
    localparam logic [DUTY_W-1:0] RST_FAST_DUTY       = 8'd167;
    localparam logic [DUTY_W-1:0] RST_SLOW_DUTY       = 8'd130;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TARGET = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_BEGIN   = 2'd1,
        EV_RELEASE = 2'd2
    } touch_ev_t;

    typedef struct packed {
        logic                fader_enable;
        logic [HYST_W-1:0]   hysteresis;
        logic [TOUCH_W-1:0]  touch_threshold;
        logic [BAND_W-1:0]   fast_band;
        logic [DUTY_W-1:0]   fast_duty;
        logic [DUTY_W-1:0]   slow_duty;
    } cfg_t;

    typedef struct packed {
        logic                op;
        logic [WIPER_W-1:0]  wiper_sample;
        logic [TOUCH_W-1:0]  touch_sample;
        logic [TARGET_W-1:0] target_value;
    } item_t;

    typedef struct packed {
        logic              toward_low;
        logic [DUTY_W-1:0] duty;
    } drive_t;

    typedef struct packed {
        logic              motor_toward_low;
        logic [DUTY_W-1:0] motor_duty;
        logic [1:0]        touch_event;
        logic              report_valid;
        logic [MSB_W-1:0]  report_msb;
        logic [LSB_W-1:0]  report_lsb;
    } result_t;

endpackage

[hw/rtl/mfs_in_if.sv]
interface mfs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [mfs_pkg::WIPER_W-1:0]   wiper_sample;
    logic [mfs_pkg::TOUCH_W-1:0]   touch_sample;
    logic [mfs_pkg::TARGET_W-1:0]  target_value;

    modport source (output valid, output op, output wiper_sample, output touch_sample,
                    output target_value, input ready);
    modport sink   (input valid, input op, input wiper_sample, input touch_sample,
                    input target_value, output ready);
endinterface

[hw/rtl/mfs_out_if.sv]
interface mfs_out_if;
    logic                         valid;
    logic                         ready;
    logic                         motor_toward_low;
    logic [mfs_pkg::DUTY_W-1:0]   motor_duty;
    logic [1:0]                   touch_event;
    logic                         report_valid;
    logic [mfs_pkg::MSB_W-1:0]    report_msb;
    logic [mfs_pkg::LSB_W-1:0]    report_lsb;

    modport source (output valid, output motor_toward_low, output motor_duty,
                    output touch_event, output report_valid, output report_msb,
                    output report_lsb, input ready);
    modport sink   (input valid, input motor_toward_low, input motor_duty,
                    input touch_event, input report_valid, input report_msb,
                    input report_lsb, output ready);
endinterface

[hw/rtl/mfs_cfg_if.sv]
interface mfs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mfs_pkg::CFG_IDX_W-1:0]    index;
    logic [mfs_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/mfs_cfg_regs.sv]
module mfs_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    mfs_cfg_if.sink       cfg,
    output mfs_pkg::cfg_t regs
);

    mfs_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.fader_enable    <= mfs_pkg::RST_FADER_ENABLE;
            regs_reg.hysteresis      <= mfs_pkg::RST_HYSTERESIS;
            regs_reg.touch_threshold <= mfs_pkg::RST_TOUCH_THRESHOLD;
            regs_reg.fast_band       <= mfs_pkg::RST_FAST_BAND;
            regs_reg.fast_duty       <= mfs_pkg::RST_FAST_DUTY;
            regs_reg.slow_duty       <= mfs_pkg::RST_SLOW_DUTY;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mfs_pkg::CFG_FADER_ENABLE:
                    regs_reg.fader_enable <= cfg.data[0];
                mfs_pkg::CFG_HYSTERESIS:
                    regs_reg.hysteresis <= cfg.data[mfs_pkg::HYST_W-1:0];
                mfs_pkg::CFG_TOUCH_THRESHOLD:
                    regs_reg.touch_threshold <= cfg.data[mfs_pkg::TOUCH_W-1:0];
                mfs_pkg::CFG_FAST_BAND:
                    regs_reg.fast_band <= cfg.data[mfs_pkg::BAND_W-1:0];
                mfs_pkg::CFG_FAST_DUTY:
                    regs_reg.fast_duty <= cfg.data[mfs_pkg::DUTY_W-1:0];
                mfs_pkg::CFG_SLOW_DUTY:
                    regs_reg.slow_duty <= cfg.data[mfs_pkg::DUTY_W-1:0];
                default:
                    regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

[hw/rtl/mfs_drive_calc.sv]
module mfs_drive_calc (
    input  logic [mfs_pkg::POS_W-1:0]    pos,
    input  logic [mfs_pkg::TARGET_W-1:0] tgt,
    input  logic                         touched,
    input  mfs_pkg::cfg_t                regs,
    output mfs_pkg::drive_t              drive
);

    localparam int DW = mfs_pkg::DEC_W;

    logic signed [DW-1:0] pos_s;
    logic signed [DW-1:0] tgt_s;
    logic signed [DW-1:0] fb_s;
    logic signed [DW-1:0] hy_s;
    logic signed [DW-1:0] lo_fast;
    logic signed [DW-1:0] lo_slow;
    logic signed [DW-1:0] hi_fast;
    logic signed [DW-1:0] hi_slow;

    assign pos_s   = DW'(pos);
    assign tgt_s   = DW'(tgt);
    assign fb_s    = DW'(regs.fast_band);
    assign hy_s    = DW'(regs.hysteresis);
    assign lo_fast = tgt_s - fb_s;
    assign lo_slow = tgt_s - hy_s;
    assign hi_fast = tgt_s + fb_s;
    assign hi_slow = tgt_s + hy_s;

    always_comb
    begin
        drive.toward_low = 1'b1;
        drive.duty       = '0;
        priority if (touched)
        begin
            drive.toward_low = 1'b1;
            drive.duty       = '0;
        end
        else if (pos_s < lo_fast)
        begin
            drive.toward_low = 1'b0;
            drive.duty       = regs.fast_duty;
        end
        else if (pos_s < lo_slow)
        begin
            drive.toward_low = 1'b0;
            drive.duty       = regs.slow_duty;
        end
        else if (pos_s > hi_fast)
        begin
            drive.toward_low = 1'b1;
            drive.duty       = regs.fast_duty;
        end
        // hysteresis above fast band leaves the slow region empty
        else if (pos_s > hi_slow && pos_s <= hi_fast)
        begin
            drive.toward_low = 1'b1;
            drive.duty       = regs.slow_duty;
        end
        else
        begin
            drive.toward_low = 1'b1;
            drive.duty       = '0;
        end
    end

endmodule

[hw/rtl/mfs_servo_core.sv]
module mfs_servo_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  mfs_pkg::item_t   item,
    input  mfs_pkg::cfg_t    regs,
    output mfs_pkg::result_t result
);

    localparam int PW = mfs_pkg::POS_W;
    localparam int FW = mfs_pkg::FILT_W;

    logic [PW-1:0]                 filt_pos_reg,  filt_pos_next;
    logic [PW-1:0]                 last_rep_reg,  last_rep_next;
    logic [mfs_pkg::TARGET_W-1:0]  target_reg,    target_next;
    logic                          touched_reg,   touched_next;
    logic                          announced_reg, announced_next;
    mfs_pkg::drive_t               drive_reg,     drive_next;

    logic [PW-1:0]   raw;
    logic [FW-1:0]   raw_plus;
    logic [FW-1:0]   filt_plus;
    mfs_pkg::drive_t drive_calc;

    assign raw       = PW'(item.wiper_sample);
    assign raw_plus  = FW'(raw) + FW'(regs.hysteresis);
    assign filt_plus = FW'(filt_pos_reg) + FW'(regs.hysteresis);

    mfs_drive_calc u_drive (
        .pos     (filt_pos_next),
        .tgt     (target_next),
        .touched (touched_next),
        .regs    (regs),
        .drive   (drive_calc)
    );

    always_comb
    begin
        filt_pos_next  = filt_pos_reg;
        last_rep_next  = last_rep_reg;
        target_next    = target_reg;
        touched_next   = touched_reg;
        announced_next = announced_reg;
        drive_next     = drive_reg;

        result.motor_toward_low = drive_reg.toward_low;
        result.motor_duty       = drive_reg.duty;
        result.touch_event      = mfs_pkg::EV_NONE;
        result.report_valid     = 1'b0;
        result.report_msb       = '0;
        result.report_lsb       = '0;

        if (regs.fader_enable)
        begin
            if (item.op == mfs_pkg::OP_SAMPLE)
            begin
                if (FW'(filt_pos_reg) > raw_plus || FW'(raw) > filt_plus)
                    filt_pos_next = raw;
                touched_next = item.touch_sample > regs.touch_threshold;
            end
            else
            begin
                target_next = item.target_value;
            end

            drive_next              = drive_calc;
            result.motor_toward_low = drive_calc.toward_low;
            result.motor_duty       = drive_calc.duty;

            if (touched_next && !announced_reg)
            begin
                announced_next     = 1'b1;
                result.touch_event = mfs_pkg::EV_BEGIN;
            end
            else if (!touched_next && announced_reg)
            begin
                announced_next     = 1'b0;
                result.touch_event = mfs_pkg::EV_RELEASE;
            end

            if (touched_next && filt_pos_next != last_rep_reg)
            begin
                last_rep_next       = filt_pos_next;
                result.report_valid = 1'b1;
                result.report_msb   = mfs_pkg::MSB_W'(filt_pos_next >> 3);
                result.report_lsb   = filt_pos_next[mfs_pkg::LSB_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_pos_reg          <= '0;
            last_rep_reg          <= '0;
            target_reg            <= '0;
            touched_reg           <= 1'b0;
            announced_reg         <= 1'b0;
            drive_reg.toward_low  <= 1'b1;
            drive_reg.duty        <= '0;
        end
        else if (advance)
        begin
            filt_pos_reg  <= filt_pos_next;
            last_rep_reg  <= last_rep_next;
            target_reg    <= target_next;
            touched_reg   <= touched_next;
            announced_reg <= announced_next;
            drive_reg     <= drive_next;
        end
    end

endmodule

[hw/rtl/motor_fader_servo_top.sv]
// Motorized fader servo. Takes wiper/touch samples and target updates, one
// request per cycle at full rate while the result side does not stall, and returns
// exactly one result per request through an input register, then a result register. The
// servo state is updated as a request moves from the input register to the result register, so
// back-to-back requests always see the state left by the one before. Config
// writes are always accepted and must only be issued while the block is idle.
module motor_fader_servo_top (
    input  logic     clk,
    input  logic     rst_n,
    mfs_in_if.sink   sample,
    mfs_out_if.source result,
    mfs_cfg_if.sink  cfg
);

    mfs_pkg::cfg_t    regs;
    mfs_pkg::result_t core_result;

    logic             s1_valid_reg;
    mfs_pkg::item_t   s1_item_reg;
    logic             out_valid_reg;
    mfs_pkg::result_t out_reg;
    logic             advance;

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;

    mfs_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mfs_servo_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .regs    (regs),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.valid && sample.ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_item_reg.op           <= sample.op;
            s1_item_reg.wiper_sample <= sample.wiper_sample;
            s1_item_reg.touch_sample <= sample.touch_sample;
            s1_item_reg.target_value <= sample.target_value;
        end
        if (advance)
            out_reg <= core_result;
    end

    assign result.valid            = out_valid_reg;
    assign result.motor_toward_low = out_reg.motor_toward_low;
    assign result.motor_duty       = out_reg.motor_duty;
    assign result.touch_event      = out_reg.touch_event;
    assign result.report_valid     = out_reg.report_valid;
    assign result.report_msb       = out_reg.report_msb;
    assign result.report_lsb       = out_reg.report_lsb;

    // a touch begin always comes with the motor halted
    a_begin_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.touch_event == mfs_pkg::EV_BEGIN
        |-> out_reg.motor_duty == '0 && out_reg.motor_toward_low)
        else $error("touch begin with motor running");

    // reports are only issued while touched, hence halted
    a_report_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.report_valid
        |-> out_reg.motor_duty == '0 && out_reg.motor_toward_low)
        else $error("position report with motor running");

    a_no_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.report_valid
        |-> out_reg.report_msb == '0 && out_reg.report_lsb == '0)
        else $error("report fields set without report");

    // a held input request is not dropped while the result side stalls
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("input register lost a request");

endmodule

[dv/mfs_checker.sv]
`timescale 1ns / 100ps

module mfs_checker
    import mfs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mfs_in_if    sample,
    mfs_out_if   result,
    mfs_cfg_if   cfg,
    output int   fail_count,
    output int   pending,
    output int   checked_count,
    output int   touch_edges,
    output int   report_count
);

    // Shadow of the register file and of the servo state
    cfg_t                regs;
    logic [POS_W-1:0]    pos_q;
    logic [POS_W-1:0]    last_rep_q;
    logic [TARGET_W-1:0] tgt_q;
    logic                touched_q;
    logic                announced_q;
    logic                dir_q;
    logic [DUTY_W-1:0]   duty_q;

    result_t due_results[$];
    result_t want;
    result_t got;
    item_t   req;

    assign pending = due_results.size();

    task automatic log_mismatch(string msg);
        if (fail_count < 10)
            $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic void write_shadow(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] d);
        unique case (idx)
            CFG_FADER_ENABLE:    regs.fader_enable    = d[0];
            CFG_HYSTERESIS:      regs.hysteresis      = d[HYST_W-1:0];
            CFG_TOUCH_THRESHOLD: regs.touch_threshold = d[TOUCH_W-1:0];
            CFG_FAST_BAND:       regs.fast_band       = d[BAND_W-1:0];
            CFG_FAST_DUTY:       regs.fast_duty       = d[DUTY_W-1:0];
            CFG_SLOW_DUTY:       regs.slow_duty       = d[DUTY_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the servo by one request and return the result it produces.
    function automatic result_t advance_servo(item_t it);
        result_t          r;
        logic [POS_W-1:0] raw;
        int               p;
        int               t;
        int               fb;
        int               hy;
        r = '0;
        if (regs.fader_enable)
        begin
            if (it.op == OP_SAMPLE)
            begin
                raw = it.wiper_sample[POS_W-1:0];
                if (int'(pos_q) > int'(raw) + int'(regs.hysteresis) ||
                    int'(raw) > int'(pos_q) + int'(regs.hysteresis))
                    pos_q = raw;
                touched_q = it.touch_sample > regs.touch_threshold;
            end
            else
            begin
                tgt_q = it.target_value;
            end

            if (touched_q)
            begin
                dir_q  = 1'b1;
                duty_q = '0;
            end
            else
            begin
                // signed distances: target near zero needs no special handling
                p  = int'(pos_q);
                t  = int'(tgt_q);
                fb = int'(regs.fast_band);
                hy = int'(regs.hysteresis);
                if (p < t - fb)
                begin
                    dir_q  = 1'b0;
                    duty_q = regs.fast_duty;
                end
                else if (p < t - hy)
                begin
                    dir_q  = 1'b0;
                    duty_q = regs.slow_duty;
                end
                else if (p > t + fb)
                begin
                    dir_q  = 1'b1;
                    duty_q = regs.fast_duty;
                end
                else if (p > t + hy)
                begin
                    dir_q  = 1'b1;
                    duty_q = regs.slow_duty;
                end
                else
                begin
                    dir_q  = 1'b1;
                    duty_q = '0;
                end
            end

            if (touched_q && !announced_q)
            begin
                announced_q   = 1'b1;
                r.touch_event = EV_BEGIN;
            end
            else if (!touched_q && announced_q)
            begin
                announced_q   = 1'b0;
                r.touch_event = EV_RELEASE;
            end

            if (touched_q && pos_q != last_rep_q)
            begin
                last_rep_q     = pos_q;
                r.report_valid = 1'b1;
                r.report_msb   = MSB_W'(pos_q >> 3);
                r.report_lsb   = pos_q[LSB_W-1:0];
            end
        end
        r.motor_toward_low = dir_q;
        r.motor_duty       = duty_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs          = '{RST_FADER_ENABLE, RST_HYSTERESIS, RST_TOUCH_THRESHOLD,
                              RST_FAST_BAND, RST_FAST_DUTY, RST_SLOW_DUTY};
            pos_q         = '0;
            last_rep_q    = '0;
            tgt_q         = '0;
            touched_q     = 1'b0;
            announced_q   = 1'b0;
            dir_q         = 1'b1;
            duty_q        = '0;
            fail_count    = 0;
            checked_count = 0;
            touch_edges   = 0;
            report_count  = 0;
            due_results.delete();
        end
        else
        begin
            if (result.valid === 1'b1 && result.ready === 1'b1)
            begin
                got = '{result.motor_toward_low, result.motor_duty, result.touch_event,
                        result.report_valid, result.report_msb, result.report_lsb};
                if (due_results.size() == 0)
                begin
                    log_mismatch("result arrived with no request outstanding");
                end
                else
                begin
                    want = due_results.pop_front();
                    checked_count++;
                    if (want.touch_event != EV_NONE)
                        touch_edges++;
                    if (want.report_valid)
                        report_count++;
                    if (got.motor_toward_low !== want.motor_toward_low ||
                        got.motor_duty !== want.motor_duty ||
                        got.touch_event !== want.touch_event ||
                        got.report_valid !== want.report_valid ||
                        got.report_msb !== want.report_msb ||
                        got.report_lsb !== want.report_lsb)
                        log_mismatch($sformatf(
                            {"result %0d mismatch: exp dir=%0d duty=%0d ev=%0d rv=%0d ",
                             "msb=%0d lsb=%0d, got dir=%0d duty=%0d ev=%0d rv=%0d ",
                             "msb=%0d lsb=%0d"},
                            checked_count,
                            want.motor_toward_low, want.motor_duty, want.touch_event,
                            want.report_valid, want.report_msb, want.report_lsb,
                            got.motor_toward_low, got.motor_duty, got.touch_event,
                            got.report_valid, got.report_msb, got.report_lsb));
                end
            end

            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
                write_shadow(cfg.index, cfg.data);

            if (sample.valid === 1'b1 && sample.ready === 1'b1)
            begin
                req = '{sample.op, sample.wiper_sample, sample.touch_sample,
                        sample.target_value};
                due_results.push_back(advance_servo(req));
            end
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import mfs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

    logic clk;
    logic rst_n;

    mfs_in_if  sample_ch ();
    mfs_out_if result_ch ();
    mfs_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int checked_count;
    int touch_edges;
    int report_count;

    int   idle_pct;
    int   n_sent;
    int   n_disabled;
    int   n_settings;
    int   last_wiper;
    bit   touching;
    cfg_t cur;
    cfg_t plan;

    motor_fader_servo_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    mfs_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample_ch),
        .result        (result_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .touch_edges   (touch_edges),
        .report_count  (report_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        int stall;
        stall = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_pct == 0)
                stall = 0;
            if (stall > 0)
            begin
                stall--;
                result_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                stall = $urandom_range(1, 16) - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic send_item(item_t it);
        int gap;
        @(negedge clk);
        sample_ch.valid        <= 1'b1;
        sample_ch.op           <= it.op;
        sample_ch.wiper_sample <= it.wiper_sample;
        sample_ch.touch_sample <= it.touch_sample;
        sample_ch.target_value <= it.target_value;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        n_sent++;
        if (!cur.fader_enable)
            n_disabled++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            sample_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_req(logic op, int w, int tch, int tg);
        send_item('{op, WIPER_W'(w), TOUCH_W'(tch), TARGET_W'(tg)});
    endtask

    // Stop sending and let every outstanding request come back.
    task automatic drain();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Unused upper data bits are filled with noise; the block must drop them.
    task automatic apply_settings(cfg_t c);
        cur = c;
        write_reg(CFG_HYSTERESIS,      {6'($urandom), c.hysteresis});
        write_reg(CFG_TOUCH_THRESHOLD, c.touch_threshold);
        write_reg(CFG_FAST_BAND,       {2'($urandom), c.fast_band});
        write_reg(CFG_FAST_DUTY,       {8'($urandom), c.fast_duty});
        write_reg(CFG_SLOW_DUTY,       {8'($urandom), c.slow_duty});
        write_reg(CFG_FADER_ENABLE,    {15'($urandom), c.fader_enable});
        n_settings++;
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        c.fader_enable    = 1'b1;
        c.hysteresis      = ($urandom_range(0, 3) == 0) ? HYST_W'($urandom)
                                                        : HYST_W'($urandom_range(0, 24));
        c.touch_threshold = TOUCH_W'($urandom);
        c.fast_band       = ($urandom_range(0, 3) == 0) ? BAND_W'($urandom)
                                                        : BAND_W'($urandom_range(0, 400));
        c.fast_duty       = DUTY_W'($urandom);
        c.slow_duty       = DUTY_W'($urandom);
        return c;
    endfunction

    // Mostly wiper moves near the last position, touch readings around the
    // threshold with sticky touch runs, and targets near the wiper.
    function automatic item_t random_req();
        item_t it;
        int    v;
        int    hy;
        int    fb;
        int    thr;
        hy  = int'(cur.hysteresis);
        fb  = int'(cur.fast_band);
        thr = int'(cur.touch_threshold);
        it.op           = ($urandom_range(0, 3) == 0) ? OP_TARGET : OP_SAMPLE;
        it.wiper_sample = WIPER_W'($urandom);
        it.touch_sample = TOUCH_W'($urandom);
        it.target_value = TARGET_W'($urandom);
        if (it.op == OP_SAMPLE)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                v = last_wiper + int'($urandom_range(0, 2 * hy + 4)) - (hy + 2);
                it.wiper_sample = WIPER_W'(clamp(v, 0, 1023));
            end
            last_wiper = int'(it.wiper_sample);
            if ($urandom_range(0, 9) == 0)
                touching = !touching;
            if ($urandom_range(0, 9) < 8)
            begin
                v = touching ? thr + int'($urandom_range(0, 300))
                             : thr - int'($urandom_range(0, 300));
                it.touch_sample = TOUCH_W'(clamp(v, 0, 65535));
            end
        end
        else if ($urandom_range(0, 9) < 7)
        begin
            v = last_wiper + int'($urandom_range(0, 2 * (fb + hy) + 8)) - (fb + hy + 4);
            it.target_value = TARGET_W'(clamp(v, 0, 16383));
        end
        return it;
    endfunction

    task automatic run_random(int n);
        repeat (n) send_item(random_req());
        drain();
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.op           = OP_SAMPLE;
        sample_ch.wiper_sample = '0;
        sample_ch.touch_sample = '0;
        sample_ch.target_value = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = CFG_FADER_ENABLE;
        cfg_ch.data            = '0;
        idle_pct               = 20;
        n_sent                 = 0;
        n_disabled             = 0;
        n_settings             = 0;
        last_wiper             = 0;
        touching               = 1'b0;
        cur = '{RST_FADER_ENABLE, RST_HYSTERESIS, RST_TOUCH_THRESHOLD,
                RST_FAST_BAND, RST_FAST_DUTY, RST_SLOW_DUTY};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: band 4, fast band 150, threshold 1000
        send_req(OP_SAMPLE, 0, 0, 0);          // at target, halted
        send_req(OP_TARGET, 0, 0, 16383);      // far above: fast toward high
        send_req(OP_SAMPLE, 1023, 0, 0);
        send_req(OP_TARGET, 0, 0, 1123);       // slow region
        send_req(OP_TARGET, 0, 0, 1027);       // exactly on stop band edge
        send_req(OP_TARGET, 0, 0, 1028);
        send_req(OP_TARGET, 0, 0, 1173);       // fast band edge, still slow
        send_req(OP_TARGET, 0, 0, 1174);
        send_req(OP_TARGET, 0, 0, 0);          // far below: fast toward low
        send_req(OP_TARGET, 0, 0, 1000);
        send_req(OP_SAMPLE, 1021, 65535, 0);   // touch begins, full-scale report
        send_req(OP_SAMPLE, 500, 65535, 0);
        send_req(OP_SAMPLE, 503, 1001, 0);     // inside dead band: no report
        send_req(OP_TARGET, 0, 0, 9000);       // target while touched stays halted
        send_req(OP_SAMPLE, 505, 1000, 0);     // reading equal to threshold: release
        send_req(OP_SAMPLE, 0, 1001, 0);
        send_req(OP_SAMPLE, 1023, 1001, 0);
        send_req(OP_SAMPLE, 1023, 0, 0);
        send_req(OP_SAMPLE, 8, 0, 0);
        send_req(OP_TARGET, 0, 0, 3);          // target below the stop band
        last_wiper = 8;
        drain();

        write_reg(CFG_SPARE, 16'($urandom));
        plan = '{1'b1, 10'd0, 16'd0, 14'd0, 8'd255, 8'd0};
        apply_settings(plan);
        run_random(60);

        plan = '{1'b1, 10'd1023, 16'd65535, 14'd16383, 8'd0, 8'd255};
        apply_settings(plan);
        run_random(60);

        // stop band wider than fast band: no slow region
        plan = '{1'b1, 10'd1023, 16'd32768, 14'd0, 8'd200, 8'd100};
        apply_settings(plan);
        run_random(60);

        plan = random_settings();
        plan.fader_enable = 1'b0;
        apply_settings(plan);
        run_random(40);

        repeat (6)
        begin
            apply_settings(random_settings());
            run_random(50);
        end

        plan = '{RST_FADER_ENABLE, RST_HYSTERESIS, RST_TOUCH_THRESHOLD,
                 RST_FAST_BAND, RST_FAST_DUTY, RST_SLOW_DUTY};
        apply_settings(plan);
        idle_pct = 0;
        run_random(80);
        repeat (8) @(posedge clk);

        $display("Sent %0d requests (%0d with the fader disabled) over %0d register settings.",
                 n_sent, n_disabled, n_settings);
        $display("Checked %0d results: %0d touch edges, %0d position reports, %0d mismatches.",
                 checked_count, touch_edges, report_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
